[rtl/upd_pkg.sv]
`default_nettype none
package upd_pkg;

   // One request: a raw byte of the encoded string and its end marker.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   // One response: a decoded character (low 8 bits) and its flags.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
   } rsp_type;

   // One queue entry: at most one percent-decoded byte, tagged with the end marker.
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       eos;
   } token_type;

   // Escape tracking in the front part.
   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_PCT  = 3'b010,
      ESC_HEX  = 3'b100
   } esc_state_type;

   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // Nibble of a hex digit; letters of either case carry bit 6.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      hex_nibble = c[6] ? (c[3:0] + 4'd9) : c[3:0];
   endfunction

endpackage
`default_nettype wire

[rtl/upd_front.sv]
`default_nettype none
module upd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire upd_pkg::req_type  req_data,
   output logic                   push_valid,
   output upd_pkg::token_type     push_data,
   input  wire logic              queue_full
);
   import upd_pkg::*;

   esc_state_type esc_ff, esc_in;
   logic [7:0]    held_ff, held_in;
   logic          pend_valid_ff, pend_valid_in;
   token_type     pend_ff, pend_in;

   logic          accept;
   logic [7:0]    b;
   logic          eos;
   logic [1:0]    n;
   logic [7:0]    byte0, byte1;
   esc_state_type esc_next;
   logic [7:0]    held_next;
   token_type     tok0;

   assign req_stall = pend_valid_ff | queue_full;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_data.in_byte;
   assign eos       = req_data.end_of_string;

   // Percent decoding of one request: zero to two output bytes.
   always_comb begin
      n         = 2'd0;
      byte0     = b;
      byte1     = b;
      esc_next  = ESC_IDLE;
      held_next = held_ff;
      unique case (esc_ff)
         ESC_PCT: begin
            if (is_hex(b)) begin
               esc_next  = ESC_HEX;
               held_next = b;
            end else if (b == CHAR_PERCENT) begin
               esc_next = ESC_PCT;
            end else if (b == CHAR_PLUS) begin
               n     = 2'd1;
               byte0 = CHAR_SPACE;
            end else begin
               n = 2'd1;
            end
         end
         ESC_HEX: begin
            held_next = 8'd0;
            if (is_hex(b)) begin
               n     = 2'd1;
               byte0 = {hex_nibble(held_ff), hex_nibble(b)};
            end else begin
               byte0 = held_ff;
               if (b == CHAR_PERCENT) begin
                  n        = 2'd1;
                  esc_next = ESC_PCT;
               end else if (b == CHAR_PLUS) begin
                  n     = 2'd2;
                  byte1 = CHAR_SPACE;
               end else begin
                  n = 2'd2;
               end
            end
         end
         default: begin
            if (b == CHAR_PERCENT) begin
               esc_next = ESC_PCT;
            end else if (b == CHAR_PLUS) begin
               n     = 2'd1;
               byte0 = CHAR_SPACE;
            end else begin
               n = 2'd1;
            end
         end
      endcase
      // Pass on a lone first digit at end of string; drop a lone percent.
      if (eos && (esc_next == ESC_HEX)) begin
         n     = 2'd1;
         byte0 = b;
      end
      if (eos) begin
         esc_next  = ESC_IDLE;
         held_next = 8'd0;
      end
   end

   always_comb begin
      tok0.data     = byte0;
      tok0.has_byte = (n != 2'd0);
      tok0.eos      = eos & (n != 2'd2);
   end

   always_comb begin
      esc_in        = esc_ff;
      held_in       = held_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      push_valid    = 1'b0;
      push_data     = tok0;
      if (pend_valid_ff) begin
         push_data = pend_ff;
         if (!queue_full) begin
            push_valid    = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else if (accept) begin
         esc_in     = esc_next;
         held_in    = held_next;
         push_valid = (n != 2'd0) | eos;
         if (n == 2'd2) begin
            pend_valid_in    = 1'b1;
            pend_in.data     = byte1;
            pend_in.has_byte = 1'b1;
            pend_in.eos      = eos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff        <= ESC_IDLE;
         held_ff       <= 8'd0;
         pend_valid_ff <= 1'b0;
      end else begin
         esc_ff        <= esc_in;
         held_ff       <= held_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

endmodule
`default_nettype wire

[rtl/upd_queue.sv]
`default_nettype none
module upd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire upd_pkg::token_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output upd_pkg::token_type      head
);
   import upd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   token_type       slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push_valid & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/upd_back.sv]
`default_nettype none
module upd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               queue_empty,
   input  wire upd_pkg::token_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output upd_pkg::rsp_type        rsp_data
);
   import upd_pkg::*;

   logic [2:0] rem_ff, rem_in;
   logic [7:0] acc_ff, acc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       can_load;
   logic [7:0] b;
   logic [2:0] rem_next;
   logic [7:0] acc_next;
   logic [7:0] ch;
   logic       char_done;
   logic       emit;
   rsp_type    res;

   assign can_load  = ~rsp_valid_ff | ~rsp_stall;
   assign pop       = ~queue_empty & can_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign b         = head.data;

   // UTF-8 step on one byte, then the end-of-string flush.
   always_comb begin
      rem_next  = rem_ff;
      acc_next  = acc_ff;
      ch        = b;
      char_done = 1'b0;
      if (head.has_byte) begin
         if (rem_ff != 3'd0) begin
            acc_next = {acc_ff[1:0], b[5:0]};
            rem_next = rem_ff - 3'd1;
            if (rem_ff == 3'd1) begin
               ch        = acc_next;
               char_done = 1'b1;
               acc_next  = 8'd0;
            end
         end else if (!b[7]) begin
            char_done = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            acc_next = {3'd0, b[4:0]};
            rem_next = 3'd1;
         end else if (b[7:4] == 4'b1110) begin
            acc_next = {4'd0, b[3:0]};
            rem_next = 3'd2;
         end else if (b[7:3] == 5'b11110) begin
            acc_next = {5'd0, b[2:0]};
            rem_next = 3'd3;
         end else if (b[7:2] == 6'b111110) begin
            acc_next = {6'd0, b[1:0]};
            rem_next = 3'd4;
         end else if (b[7:1] == 7'b1111110) begin
            acc_next = {7'd0, b[0]};
            rem_next = 3'd5;
         end else begin
            ch        = CHAR_QUESTION;
            char_done = 1'b1;
         end
      end

      emit            = char_done;
      res.out_byte    = ch;
      res.byte_valid  = 1'b1;
      res.string_done = 1'b0;
      if (head.eos) begin
         emit            = 1'b1;
         res.string_done = 1'b1;
         if (!char_done) begin
            if (rem_next == 3'd1) begin
               res.out_byte = {acc_next[1:0], 6'd0};
            end else if (rem_next != 3'd0) begin
               res.out_byte = 8'd0;
            end else begin
               res.out_byte   = 8'd0;
               res.byte_valid = 1'b0;
            end
         end
         rem_next = 3'd0;
         acc_next = 8'd0;
      end
   end

   always_comb begin
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (can_load) begin
         rsp_valid_in = 1'b0;
         if (pop) begin
            rem_in       = rem_next;
            acc_in       = acc_next;
            rsp_valid_in = emit;
            rsp_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= 3'd0;
         acc_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

[rtl/url_percent_utf8_decoder_core.sv]
// URL percent decoder with UTF-8 to 8-bit character reduction.
// Request channel (req_valid / req_stall / req_data): one raw byte of the
// encoded string per request, end_of_string set on the final byte.
// Response channel (rsp_valid / rsp_stall / rsp_data): one decoded
// character per response; string_done marks the last response of a string,
// byte_valid is low on a bare end marker.
// A front part undoes the percent escapes and '+', a token queue of
// QUEUE_DEPTH entries follows, and a back part assembles UTF-8 sequences
// into a registered response.
// A token passes the queue slot and then the response register.
// Throughput: one request per cycle while req_stall is low; a broken
// escape "%X" then a plain byte yields two tokens and holds req_stall.
// Reset: escape and sequence state clear, the queue empties, rsp_valid
// drops. When the receiver stalls, the response holds, the queue fills,
// and req_stall rises once the queue is full.
`default_nettype none
module url_percent_utf8_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire upd_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output upd_pkg::rsp_type       rsp_data
);
   import upd_pkg::*;

   // Front to queue: push a token, hold while the queue is full.
   logic      push_valid;
   token_type push_data;
   logic      queue_full;

   // Queue to back: advance the head when the response register frees up.
   logic      queue_empty;
   logic      pop;
   token_type head;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   upd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
